/* src/range_min_segment_tree_top_defines.svh */
// ---------------------------------------------------------------------------
// range_min_segment_tree_top_defines
// assertion macros shared by the range-minimum tree checker
// ---------------------------------------------------------------------------
`ifndef RANGE_MIN_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_TOP_DEFINES_SVH

// same-cycle implication
`define RMST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RMST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/rmst_pkg.sv */
// ---------------------------------------------------------------------------
// rmst_pkg
// types, codes and helpers for the range-minimum segment tree
// ---------------------------------------------------------------------------
package rmst_pkg;

   localparam int VAL_W      = 15;
   localparam int POS_W      = 10;
   localparam int ADDR_MAX_W = 17;

   localparam logic [VAL_W-1:0] EMPTY_VALUE = 15'd25005;

   localparam logic CMD_LOWER = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_WALK,
      ST_QRY_A,
      ST_QRY_B,
      ST_QRY_OUT
   } state_type;

   // node memory access for one cycle
   typedef struct packed {
      logic                  rd_en;
      logic [ADDR_MAX_W-1:0] rd_addr;
      logic                  wr_en;
      logic [ADDR_MAX_W-1:0] wr_addr;
      logic [VAL_W-1:0]      wr_data;
   } mem_req_type;

   function automatic logic [VAL_W-1:0] lesser(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

/* src/range_min_segment_tree_top.sv */
// ---------------------------------------------------------------------------
// range_min_segment_tree_top
// range-minimum segment tree with point lowering updates
// ---------------------------------------------------------------------------
//  channel   ports       beat contents
//  ------    --------    ---------------------------------------------------
//  request   req_*       command, position, value, query_low, query_high
//  response  rsp_*       minimum (one beat per query, none per update)
//
//  update: accept with leaf read, leaf refresh, then one walk step per level up to the root; one memory port pair
//  query: ST_QRY_A and ST_QRY_B per walk level through the single read port
//    (accept, level pairs, end check, output)
//  reset runs a clearing pass over every node, req_ready held low
//  a finished query waits in the output register; a stalled response only
//    holds the block if the next query finishes before it is taken
// ---------------------------------------------------------------------------
module range_min_segment_tree_top import rmst_pkg::*; #(
   parameter int POSITIONS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  logic [POS_W-1:0] req_position,
   input  logic [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0] req_query_low,
   input  logic [POS_W-1:0] req_query_high,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_minimum
);

   // bottom-up layout: leaf p at node POSITIONS + p, node 1 is the root
   localparam int NODES = 2 * POSITIONS;
   localparam int AW    = $clog2(NODES);
   // walk bounds reach 2 * POSITIONS, one bit more than a node address
   localparam int CW    = AW + 1;

   mem_req_type      mem_req;
   logic [VAL_W-1:0] rd_data;

   rmst_node_mem #(
      .DEPTH (NODES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   rmst_ctrl #(
      .POSITIONS (POSITIONS),
      .CW        (CW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_query_low  (req_query_low),
      .req_query_high (req_query_high),
      .mem_req        (mem_req),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_minimum    (rsp_minimum)
   );

endmodule

/* src/rmst_node_mem.sv */
// ---------------------------------------------------------------------------
// rmst_node_mem
// node minima storage, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module rmst_node_mem import rmst_pkg::*; #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic             clock,
   input  mem_req_type      mem_req,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rmst_ctrl.sv */
// ---------------------------------------------------------------------------
// rmst_ctrl
// sequencer for clearing, point lowering and range queries
// ---------------------------------------------------------------------------
module rmst_ctrl import rmst_pkg::*; #(
   parameter int POSITIONS = 1024,
   parameter int CW        = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  logic [POS_W-1:0] req_position,
   input  logic [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0] req_query_low,
   input  logic [POS_W-1:0] req_query_high,
   output mem_req_type      mem_req,
   input  logic [VAL_W-1:0] rd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_minimum
);

   localparam logic [31:0] P32      = 32'(POSITIONS);
   localparam logic [CW-1:0] LAST_NODE = CW'(2 * POSITIONS - 1);
   localparam logic [CW-1:0] ROOT     = CW'(1);

   state_type        state_ff, state_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    b_ff, b_in;
   logic [VAL_W-1:0] cur_ff, cur_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_min_ff, rsp_min_in;

   logic             accept;
   logic             pos_ok;
   logic [31:0]      hi32;
   logic             range_ok;
   logic [CW-1:0]    leaf;
   logic [CW-1:0]    a_start;
   logic [CW-1:0]    b_start;
   logic [CW-1:0]    parent;
   logic [CW-1:0]    b_dec;
   logic [VAL_W-1:0] acc;
   logic [VAL_W-1:0] leaf_new;
   logic [VAL_W-1:0] walk_new;
   logic             out_free;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_minimum = rsp_min_ff;

   always_comb begin
      pos_ok   = 32'(req_position) < P32;
      hi32     = (32'(req_query_high) >= P32) ? (P32 - 32'd1) : 32'(req_query_high);
      range_ok = 32'(req_query_low) <= hi32;
      leaf     = CW'(P32 + 32'(req_position));
      a_start  = CW'(P32 + 32'(req_query_low));
      b_start  = CW'(P32 + hi32 + 32'd1);
      parent   = idx_ff >> 1;
      b_dec    = b_ff - CW'(1);
      acc      = pend_ff ? lesser(cur_ff, rd_data) : cur_ff;
      leaf_new = lesser(rd_data, val_ff);
      walk_new = lesser(cur_ff, rd_data);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_QUERY) begin
                  state_in = ST_QRY_A;
               end else if (pos_ok) begin
                  state_in = ST_UPD_LEAF;
               end
            end
         end
         ST_UPD_LEAF: state_in = ST_UPD_WALK;
         ST_UPD_WALK: begin
            if (parent == ROOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY_A: begin
            state_in = (idx_ff < b_ff) ? ST_QRY_B : ST_QRY_OUT;
         end
         ST_QRY_B: state_in = ST_QRY_A;
         ST_QRY_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory access
   always_comb begin
      idx_in       = idx_ff;
      b_in         = b_ff;
      cur_in       = cur_ff;
      val_in       = val_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      mem_req      = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_MAX_W'(idx_ff);
            mem_req.wr_data = EMPTY_VALUE;
            idx_in          = idx_ff + CW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_QUERY) begin
                  idx_in = range_ok ? a_start : '0;
                  b_in   = range_ok ? b_start : '0;
                  cur_in = EMPTY_VALUE;
               end else if (pos_ok) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = ADDR_MAX_W'(leaf);
                  idx_in          = leaf;
                  val_in          = req_value;
               end
            end
         end
         ST_UPD_LEAF: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_MAX_W'(idx_ff);
            mem_req.wr_data = leaf_new;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ADDR_MAX_W'(idx_ff ^ CW'(1));
            cur_in          = leaf_new;
         end
         ST_UPD_WALK: begin
            // rd_data is the sibling of the node just refreshed
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ADDR_MAX_W'(parent);
            mem_req.wr_data = walk_new;
            cur_in          = walk_new;
            idx_in          = parent;
            if (parent != ROOT) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ADDR_MAX_W'(parent ^ CW'(1));
            end
         end
         ST_QRY_A: begin
            cur_in = acc;
            if ((idx_ff < b_ff) && idx_ff[0]) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ADDR_MAX_W'(idx_ff);
               pend_in         = 1'b1;
               idx_in          = idx_ff + CW'(1);
            end
         end
         ST_QRY_B: begin
            cur_in = acc;
            idx_in = idx_ff >> 1;
            if (b_ff[0]) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ADDR_MAX_W'(b_dec);
               pend_in         = 1'b1;
               b_in            = b_dec >> 1;
            end else begin
               b_in = b_ff >> 1;
            end
         end
         ST_QRY_OUT: begin
            cur_in = acc;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = acc;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff       <= b_in;
      cur_ff     <= cur_in;
      val_ff     <= val_in;
      rsp_min_ff <= rsp_min_in;
   end

endmodule

/* src/rmst_checker.sv */
// ---------------------------------------------------------------------------
// rmst_checker
// port-level checks for the range-minimum segment tree
// ---------------------------------------------------------------------------
`include "range_min_segment_tree_top_defines.svh"

module rmst_checker import rmst_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_command,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [VAL_W-1:0] rsp_minimum
);

   `RMST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_minimum), "response beat dropped or changed while stalled")
   `RMST_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready && !rsp_valid, "block ready or responding during clearing pass")
   `RMST_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && (req_command == CMD_QUERY), !req_ready, "query accepted without busy period")
   `RMST_ASSERT_NOW(a_min_bound, clock, reset, rsp_valid, rsp_minimum <= EMPTY_VALUE, "minimum above empty value")

endmodule

bind range_min_segment_tree_top rmst_checker u_rmst_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_minimum (rsp_minimum)
);
